// ===== rtl/las_pkg.sv =====
// ----------------------------------------------------------------------------
// Local alignment score package
// Shared constants, codes, record types and the best-cell selection function.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int QUERY_MAX = 256;
  localparam int DB_MAX    = 65535;
  localparam int SCORE_W   = 16;
  localparam int SYM_W     = 8;
  localparam int QIDX_W    = $clog2(QUERY_MAX);
  localparam int COL_W     = $clog2(QUERY_MAX + 1);
  localparam int ROW_W     = $clog2(DB_MAX + 1);
  localparam int SUM_W     = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
  localparam int EXT_W     = SCORE_W + 2;
  localparam int MATCH_W   = 4;
  localparam int PEN_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH    = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_DB    = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [MATCH_W-1:0]      match_val;
    logic signed [PEN_W-1:0] mismatch_score;
    logic signed [PEN_W-1:0] gap_val;
  } scores_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } best_t;

  // One slot of the systolic row: a database symbol with its row scores.
  typedef struct packed {
    logic               vld;
    logic               calc;
    logic               last;
    logic [SYM_W-1:0]   sym;
    logic [ROW_W-1:0]   row;
    logic [SCORE_W-1:0] h_left;
    logic [SCORE_W-1:0] h_diag;
    best_t              carry;
  } tok_t;

  typedef struct packed {
    logic             clear;
    logic             load;
    logic [QIDX_W-1:0] load_idx;
    logic [SYM_W-1:0] load_sym;
  } cell_ctl_t;

  // Picks between a candidate from lower columns (a) and one from a higher
  // column (b). Higher score wins; on a tie the smaller row+col wins, and on
  // the same anti-diagonal the larger column wins. A zero score never wins.
  function automatic best_t pick_best(best_t a, best_t b);
    logic [SUM_W-1:0] da;
    logic [SUM_W-1:0] db;
    logic             take;
    da   = SUM_W'(a.row) + SUM_W'(a.col);
    db   = SUM_W'(b.row) + SUM_W'(b.col);
    take = 1'b0;
    if (b.score > a.score) begin
      take = 1'b1;
    end else if (b.score == a.score && b.score != '0) begin
      take = (db < da) || (db == da && b.col > a.col);
    end
    return take ? b : a;
  endfunction

endpackage

// ===== rtl/las_cell.sv =====
// ----------------------------------------------------------------------------
// Alignment cell
// Holds one query symbol and its column score, computes one matrix cell per
// database symbol that passes and folds its best cell into the carried record.
// ----------------------------------------------------------------------------
module las_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [las_pkg::COL_W-1:0]     col_i,
  input  logic                          used_i,
  input  logic                          load_i,
  input  las_pkg::cell_ctl_t            ctl_i,
  input  las_pkg::scores_t              scores_i,
  input  las_pkg::tok_t                 tok_i,
  output las_pkg::tok_t                 tok_o
);

  logic [las_pkg::SYM_W-1:0]   qsym_q;
  logic [las_pkg::SCORE_W-1:0] h_up_q, h_up_d, h_up_v;
  las_pkg::best_t              own_q, own_d, own_v;
  las_pkg::tok_t               tok_q, tok_d;

  logic signed [las_pkg::EXT_W-1:0] gap_s, diag_add_s;
  logic signed [las_pkg::EXT_W-1:0] up_s, left_s, diag_s, m1_s, m2_s;
  logic [las_pkg::SCORE_W-1:0]      new_score;
  logic                             compute;

  always_comb begin
    // The first row of a run reaches the first cell in the cycle of the clear,
    // so the cleared values are used at once.
    h_up_v = ctl_i.clear ? '0 : h_up_q;
    own_v  = ctl_i.clear ? '0 : own_q;
    gap_s = {{(las_pkg::EXT_W-las_pkg::PEN_W){scores_i.gap_val[las_pkg::PEN_W-1]}},
             scores_i.gap_val};
    if (qsym_q == tok_i.sym) begin
      diag_add_s = {{(las_pkg::EXT_W-las_pkg::MATCH_W){1'b0}}, scores_i.match_val};
    end else begin
      diag_add_s = {{(las_pkg::EXT_W-las_pkg::PEN_W){scores_i.mismatch_score[las_pkg::PEN_W-1]}},
                    scores_i.mismatch_score};
    end
    up_s   = signed'({2'b00, h_up_v}) + gap_s;
    left_s = signed'({2'b00, tok_i.h_left}) + gap_s;
    diag_s = signed'({2'b00, tok_i.h_diag}) + diag_add_s;
    m1_s   = (up_s > left_s) ? up_s : left_s;
    m2_s   = (m1_s > diag_s) ? m1_s : diag_s;
    if (m2_s < 0) begin
      new_score = '0;
    end else if (m2_s > signed'({2'b00, las_pkg::SCORE_TOP})) begin
      new_score = las_pkg::SCORE_TOP;
    end else begin
      new_score = m2_s[las_pkg::SCORE_W-1:0];
    end
  end

  assign compute = tok_i.vld && tok_i.calc && used_i;

  always_comb begin
    h_up_d = h_up_v;
    own_d  = own_v;
    if (compute) begin
      h_up_d = new_score;
      // Strict compare keeps the earliest row of this column.
      if (new_score > own_v.score) begin
        own_d.score = new_score;
        own_d.row   = tok_i.row;
        own_d.col   = col_i;
      end
    end
    tok_d        = tok_i;
    tok_d.h_left = new_score;
    tok_d.h_diag = h_up_v;
    tok_d.carry  = las_pkg::pick_best(tok_i.carry, own_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      h_up_q <= '0;
      own_q  <= '0;
    end else begin
      tok_q  <= tok_d;
      h_up_q <= h_up_d;
      own_q  <= own_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      qsym_q <= ctl_i.load_sym;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/las_array.sv =====
// ----------------------------------------------------------------------------
// Alignment cell row
// A chain of QUERY_MAX cells; database symbols enter at column one and move
// one column per cycle, so each cell sees the rows in order.
// ----------------------------------------------------------------------------
module las_array (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [las_pkg::COL_W-1:0]   qlen_i,
  input  las_pkg::cell_ctl_t          ctl_i,
  input  las_pkg::scores_t            scores_i,
  input  las_pkg::tok_t               tok_i,
  output las_pkg::tok_t               tok_o
);

  las_pkg::tok_t chain [las_pkg::QUERY_MAX+1];

  assign chain[0] = tok_i;

  for (genvar i = 0; i < las_pkg::QUERY_MAX; i++) begin : g_cell
    logic used;
    logic load;
    assign used = qlen_i > las_pkg::COL_W'(i);
    assign load = ctl_i.load && (ctl_i.load_idx == las_pkg::QIDX_W'(i));

    las_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .col_i    (las_pkg::COL_W'(i + 1)),
      .used_i   (used),
      .load_i   (load),
      .ctl_i    (ctl_i),
      .scores_i (scores_i),
      .tok_i    (chain[i]),
      .tok_o    (chain[i+1])
    );
  end

  assign tok_o = chain[las_pkg::QUERY_MAX];

endmodule

// ===== rtl/local_alignment_score.sv =====
// ----------------------------------------------------------------------------
// Local alignment score
// Smith-Waterman score with linear gap penalty on a systolic row of cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfers
// s_axis    in         query load (tuser 0) or database symbol (tuser 1)
// m_axis    out        best score, row and column at the end of a run
// cfg       in         match, mismatch and gap scores by register index
//
// Within a run one database symbol is taken every cycle. The result leaves
// the last cell once the final symbol has passed the register of every cell
// in the chain. A query load, and the first symbol of a new run,
// wait until the chain has drained and, for a run, until the previous result
// was taken. Reset is asynchronous and needs no clearing pass; every run
// start clears the column scores.
// ----------------------------------------------------------------------------
module local_alignment_score (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] symbol
  input  logic                       s_axis_tuser,   // [0] opcode
  input  logic                       s_axis_tlast,   // last
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [47:0]                m_axis_tdata,   // [15:0] best_score, [31:16] best_row,
                                                     // [40:32] best_col, [47:41] zero
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [4:0]                 cfg_data_i
);

  localparam int FlightW = $clog2(las_pkg::QUERY_MAX + 1);

  las_pkg::scores_t             scores_q, scores_d;
  logic [las_pkg::COL_W-1:0]    qlen_q, qlen_d, qbase;
  logic [las_pkg::ROW_W-1:0]    dbpos_q, dbpos_d, dbpos_eff;
  logic                         run_open_q, run_open_d;
  logic [FlightW-1:0]           flight_q, flight_d;
  logic                         out_vld_q, out_vld_d;
  las_pkg::best_t               out_q, out_d;

  las_pkg::cell_ctl_t           ctl;
  las_pkg::tok_t                tok_in, tok_out;
  logic                         accept, is_db, empty, needs_reset;

  assign is_db       = (s_axis_tuser == las_pkg::OP_DB);
  assign empty       = (flight_q == '0);
  assign needs_reset = run_open_q || (dbpos_q != '0);
  assign s_axis_tready = is_db ? (run_open_q || (empty && !out_vld_q)) : empty;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    scores_d = scores_q;
    if (cfg_valid_i) begin
      case (las_pkg::cfg_idx_e'(cfg_index_i))
        las_pkg::CFG_MATCH:    scores_d.match_val      = cfg_data_i[las_pkg::MATCH_W-1:0];
        las_pkg::CFG_MISMATCH: scores_d.mismatch_score = cfg_data_i;
        las_pkg::CFG_GAP:      scores_d.gap_val        = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    qlen_d     = qlen_q;
    dbpos_d    = dbpos_q;
    run_open_d = run_open_q;
    flight_d   = empty ? flight_q : flight_q - 1'b1;
    ctl        = '0;
    tok_in     = '0;
    qbase      = needs_reset ? '0 : qlen_q;
    dbpos_eff  = run_open_q ? dbpos_q : '0;
    ctl.load_idx = qbase[las_pkg::QIDX_W-1:0];
    ctl.load_sym = s_axis_tdata;

    if (accept && !is_db) begin
      if (needs_reset) begin
        run_open_d = 1'b0;
        dbpos_d    = '0;
      end
      qlen_d = qbase;
      if (qbase < las_pkg::COL_W'(las_pkg::QUERY_MAX)) begin
        ctl.load = 1'b1;
        qlen_d   = qbase + 1'b1;
      end
    end else if (accept) begin
      ctl.clear   = !run_open_q;
      tok_in.vld  = 1'b1;
      tok_in.last = s_axis_tlast;
      tok_in.sym  = s_axis_tdata;
      tok_in.calc = dbpos_eff < las_pkg::ROW_W'(las_pkg::DB_MAX);
      tok_in.row  = dbpos_eff + 1'b1;
      dbpos_d     = tok_in.calc ? tok_in.row : dbpos_eff;
      run_open_d  = !s_axis_tlast;
      flight_d    = FlightW'(las_pkg::QUERY_MAX);
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (tok_out.vld && tok_out.last) begin
      out_vld_d = 1'b1;
      out_d     = tok_out.carry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scores_q.match_val      <= las_pkg::MATCH_W'(3);
      scores_q.mismatch_score <= -las_pkg::PEN_W'(3);
      scores_q.gap_val        <= -las_pkg::PEN_W'(2);
      qlen_q     <= '0;
      dbpos_q    <= '0;
      run_open_q <= 1'b0;
      flight_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      scores_q   <= scores_d;
      qlen_q     <= qlen_d;
      dbpos_q    <= dbpos_d;
      run_open_q <= run_open_d;
      flight_q   <= flight_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  las_array u_array (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .qlen_i   (qlen_q),
    .ctl_i    (ctl),
    .scores_i (scores_q),
    .tok_i    (tok_in),
    .tok_o    (tok_out)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_q.col, out_q.row, out_q.score};

endmodule

// ===== rtl/las_checker.sv =====
// ----------------------------------------------------------------------------
// Local alignment score checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module las_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata
);

  // A held result keeps its value until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A new result needs a full pass through the cell chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result followed a transfer too soon");

  // No positive score means no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:0] == 16'd0 |->
      m_axis_tdata[31:16] == 16'd0 && m_axis_tdata[40:32] == 9'd0)
    else $error("position reported for a zero score");

  // A positive score names a real cell inside the query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15:0] != 16'd0 |->
      m_axis_tdata[31:16] != 16'd0 && m_axis_tdata[40:32] != 9'd0 &&
      m_axis_tdata[40:32] <= 9'd256 && m_axis_tdata[47:41] == 7'd0)
    else $error("best cell position out of range");

endmodule

bind local_alignment_score las_checker u_las_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/local_alignment_score_checker.sv =====
// ----------------------------------------------------------------------------
// Local alignment score checker
// Watches the symbol, result and register channels of the block, keeps its
// own copy of the score row and best cell, and compares every result
// transfer with the oldest predicted one. Reports a running failure count and
// the number of results still awaited.
// ----------------------------------------------------------------------------
module local_alignment_score_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [las_pkg::SYM_W-1:0]     s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          s_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [47:0]                   m_tdata_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [las_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [las_pkg::PEN_W-1:0]     cfg_data_i,
  output int                            errors_o,
  output int                            outstanding_o
);

  localparam int SCORE_CAP = (1 << las_pkg::SCORE_W) - 1;

  // Predicted alignment state.
  logic [las_pkg::SYM_W-1:0]        query_syms [las_pkg::QUERY_MAX];
  int                               col_h [las_pkg::QUERY_MAX+1];
  int                               query_len;
  int                               row_cnt;
  int                               top_score;
  int                               top_row;
  int                               top_col;
  logic                             run_live;
  logic [las_pkg::MATCH_W-1:0]      match_w;
  logic signed [las_pkg::PEN_W-1:0] mismatch_w;
  logic signed [las_pkg::PEN_W-1:0] gap_w;

  las_pkg::best_t awaited [$];
  int             mismatches;

  // Fills one row of the score matrix and updates the best cell. Cells are
  // visited in rising column order, so the tie rule needs the explicit
  // anti-diagonal comparison.
  task automatic score_row(input logic [las_pkg::SYM_W-1:0] sym);
    int gap;
    int mis;
    int mat;
    int diag_prev;
    int left;
    int h_new;
    int c;
    gap       = int'(gap_w);
    mis       = int'(mismatch_w);
    mat       = int'(match_w);
    diag_prev = 0;
    left      = 0;
    for (c = 1; c <= query_len; c++) begin
      h_new = 0;
      if (col_h[c] + gap > h_new) h_new = col_h[c] + gap;
      if (left + gap > h_new) h_new = left + gap;
      if (diag_prev + ((query_syms[c-1] == sym) ? mat : mis) > h_new) begin
        h_new = diag_prev + ((query_syms[c-1] == sym) ? mat : mis);
      end
      if (h_new > SCORE_CAP) h_new = SCORE_CAP;
      diag_prev = col_h[c];
      col_h[c]  = h_new;
      left      = h_new;
      if (h_new > 0) begin
        if (h_new > top_score ||
            (h_new == top_score &&
             (row_cnt + c < top_row + top_col ||
              (row_cnt + c == top_row + top_col && c > top_col)))) begin
          top_score = h_new;
          top_row   = row_cnt;
          top_col   = c;
        end
      end
    end
  endtask

  task automatic take_db_symbol(input logic [las_pkg::SYM_W-1:0] sym, input logic fin);
    las_pkg::best_t hit;
    if (!run_live) begin
      foreach (col_h[i]) col_h[i] = 0;
      row_cnt   = 0;
      top_score = 0;
      top_row   = 0;
      top_col   = 0;
      run_live  = 1'b1;
    end
    // Rows past the database limit leave every score alone.
    if (row_cnt < las_pkg::DB_MAX) begin
      row_cnt++;
      score_row(sym);
    end
    if (fin) begin
      hit.score = las_pkg::SCORE_W'(top_score);
      hit.row   = las_pkg::ROW_W'(top_row);
      hit.col   = las_pkg::COL_W'(top_col);
      awaited.push_back(hit);
      run_live = 1'b0;
    end
  endtask

  task automatic take_query_symbol(input logic [las_pkg::SYM_W-1:0] sym);
    // A load after rows were streamed starts a fresh query.
    if (run_live || row_cnt != 0) begin
      run_live  = 1'b0;
      query_len = 0;
      row_cnt   = 0;
    end
    if (query_len < las_pkg::QUERY_MAX) begin
      query_syms[query_len] = sym;
      query_len++;
    end
  endtask

  task automatic check_result(input logic [47:0] word);
    las_pkg::best_t got;
    las_pkg::best_t want;
    got.score = word[las_pkg::SCORE_W-1:0];
    got.row   = word[las_pkg::SCORE_W+las_pkg::ROW_W-1:las_pkg::SCORE_W];
    got.col   = word[las_pkg::SCORE_W+las_pkg::ROW_W+las_pkg::COL_W-1:
                     las_pkg::SCORE_W+las_pkg::ROW_W];
    if (awaited.size() == 0) begin
      if (mismatches < 10) begin
        $display("result transfer with none awaited: score %0d row %0d col %0d",
                 got.score, got.row, got.col);
      end
      mismatches++;
    end else begin
      want = awaited.pop_front();
      if (got.score != want.score || got.row != want.row || got.col != want.col) begin
        if (mismatches < 10) begin
          $display("result mismatch: expected score %0d row %0d col %0d, got %0d %0d %0d",
                   want.score, want.row, want.col, got.score, got.row, got.col);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_w    = las_pkg::MATCH_W'(3);
      mismatch_w = -las_pkg::PEN_W'(3);
      gap_w      = -las_pkg::PEN_W'(2);
      query_len  = 0;
      row_cnt    = 0;
      top_score  = 0;
      top_row    = 0;
      top_col    = 0;
      run_live   = 1'b0;
      foreach (col_h[i]) col_h[i] = 0;
      awaited.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          las_pkg::CFG_MATCH: begin
            match_w = cfg_data_i[las_pkg::MATCH_W-1:0];
          end
          las_pkg::CFG_MISMATCH: begin
            mismatch_w = cfg_data_i;
          end
          las_pkg::CFG_GAP: begin
            gap_w = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == las_pkg::OP_DB) begin
          take_db_symbol(s_tdata_i, s_tlast_i);
        end else begin
          take_query_symbol(s_tdata_i);
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        check_result(m_tdata_i);
      end
    end
    errors_o      = mismatches;
    outstanding_o = awaited.size();
  end

endmodule

// ===== bench/local_alignment_score_tb.sv =====
// ----------------------------------------------------------------------------
// Local alignment score testbench
// Loads queries and streams database symbols through the block under a range
// of score settings and idle patterns: a directed set of corner cases, a
// query overflow, then random runs. A separate checker predicts each run's
// best cell and compares it with the result transfers.
// ----------------------------------------------------------------------------
module local_alignment_score_tb;

  localparam int                            STALL_LIMIT    = 4000;
  localparam int                            SETTLE_CYCLES  = 300;
  localparam int                            PHASE_ITEMS    = 85;
  localparam logic [las_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [las_pkg::SYM_W-1:0]     s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [47:0]                   m_axis_tdata;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [las_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [las_pkg::PEN_W-1:0]     cfg_data_i;

  int                        check_errors;
  int                        check_pending;
  int                        src_idle_pct;
  int                        sink_stall_pct;
  int                        items_sent;
  int                        quiet_cycles;
  logic                      tail_open;
  logic [las_pkg::SYM_W-1:0] alpha [4];

  local_alignment_score DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  local_alignment_score_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (check_errors),
    .outstanding_o (check_pending)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Ends the run when no channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("local_alignment_score_tb: done, errors");
        $finish;
      end
    end
  end

  // Valid stays high after a transfer; the next call either idles or drives
  // the next symbol at the following falling edge.
  task automatic push_item(input las_pkg::opcode_e op, input logic [las_pkg::SYM_W-1:0] sym,
                           input logic fin);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = sym;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic hold_src();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [las_pkg::CFG_IDX_W-1:0] idx,
                           input logic [las_pkg::PEN_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    hold_src();
    while (check_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(input int mat, input int mis, input int gap);
    drain();
    write_reg(las_pkg::CFG_MATCH, las_pkg::PEN_W'(mat));
    write_reg(las_pkg::CFG_MISMATCH, las_pkg::PEN_W'(mis));
    write_reg(las_pkg::CFG_GAP, las_pkg::PEN_W'(gap));
  endtask

  function automatic logic [las_pkg::SYM_W-1:0] pick_sym();
    if ($urandom_range(99) < 85) return alpha[$urandom_range(3)];
    return las_pkg::SYM_W'($urandom_range(255));
  endfunction

  // One run: usually a fresh query, then database rows ending in last.
  // Some runs are cut short and left open for the next one to continue
  // or abandon.
  task automatic random_run();
    int   qn;
    int   dn;
    int   k;
    logic cut;
    if ($urandom_range(99) < 75) begin
      foreach (alpha[i]) alpha[i] = las_pkg::SYM_W'($urandom_range(255));
      qn = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      for (k = 0; k < qn; k++) begin
        push_item(las_pkg::OP_QUERY, pick_sym(), 1'($urandom_range(1)));
      end
    end
    dn  = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    cut = ($urandom_range(99) < 12);
    for (k = 1; k <= dn; k++) push_item(las_pkg::OP_DB, pick_sym(), !cut && k == dn);
    tail_open = cut;
  endtask

  initial begin
    int k;
    int phase;
    int quota;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = las_pkg::OP_QUERY;
    s_axis_tlast   = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = las_pkg::CFG_MATCH;
    cfg_data_i     = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    tail_open      = 1'b0;
    rst_ni         = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // An index past the register list must change nothing.
    write_reg(CFG_UNUSED_IDX, las_pkg::PEN_W'($urandom_range(31)));

    // No query loaded yet: the run computes no cells.
    push_item(las_pkg::OP_DB, 8'h00, 1'b1);
    // Last on a query load is ignored.
    push_item(las_pkg::OP_QUERY, 8'h00, 1'b1);
    push_item(las_pkg::OP_QUERY, 8'hFF, 1'b0);
    push_item(las_pkg::OP_QUERY, 8'h5A, 1'b0);
    push_item(las_pkg::OP_DB, 8'h00, 1'b0);
    push_item(las_pkg::OP_DB, 8'hFF, 1'b0);
    push_item(las_pkg::OP_DB, 8'h5A, 1'b1);
    // A second run on the same query starts from cleared scores.
    push_item(las_pkg::OP_DB, 8'hA5, 1'b0);
    push_item(las_pkg::OP_DB, 8'h00, 1'b1);
    // Open run abandoned by a query load; the new query then sees a tie
    // between two cells on one anti-diagonal.
    push_item(las_pkg::OP_DB, 8'hFF, 1'b0);
    push_item(las_pkg::OP_QUERY, 8'hFF, 1'b0);
    push_item(las_pkg::OP_QUERY, 8'h00, 1'b0);
    push_item(las_pkg::OP_DB, 8'h00, 1'b0);
    push_item(las_pkg::OP_DB, 8'hFF, 1'b1);
    // Equal scores on different anti-diagonals, then a run with no positive cell.
    push_item(las_pkg::OP_QUERY, 8'h7E, 1'b0);
    push_item(las_pkg::OP_DB, 8'h7E, 1'b0);
    push_item(las_pkg::OP_DB, 8'h7E, 1'b1);
    push_item(las_pkg::OP_DB, 8'h11, 1'b1);

    configure(15, -16, -16);
    push_item(las_pkg::OP_QUERY, 8'hC3, 1'b0);
    push_item(las_pkg::OP_QUERY, 8'h3C, 1'b0);
    push_item(las_pkg::OP_DB, 8'hC3, 1'b0);
    push_item(las_pkg::OP_DB, 8'h3C, 1'b1);

    configure(0, 0, 0);
    push_item(las_pkg::OP_QUERY, 8'h81, 1'b0);
    push_item(las_pkg::OP_DB, 8'h81, 1'b0);
    push_item(las_pkg::OP_DB, 8'h18, 1'b1);

    // Query overflow: loads past the cell count are dropped.
    configure(15, -1, -1);
    foreach (alpha[i]) alpha[i] = las_pkg::SYM_W'($urandom_range(255));
    for (k = 0; k < las_pkg::QUERY_MAX + 4; k++) push_item(las_pkg::OP_QUERY, pick_sym(), 1'b0);
    for (k = 1; k <= 6; k++) push_item(las_pkg::OP_DB, pick_sym(), k == 6);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure(15, 0, -16);
        1: configure(1, -16, 0);
        2: configure(3, -3, -2);
        default: configure($urandom_range(15), -int'($urandom_range(16)),
                           -int'($urandom_range(16)));
      endcase
      case (phase % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 57;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 57;
        end
        default: begin
          src_idle_pct   = 28;
          sink_stall_pct = 28;
        end
      endcase
      quota = items_sent + PHASE_ITEMS;
      while (items_sent < quota || tail_open) random_run();
    end

    drain();
    if (check_errors == 0 && check_pending == 0) begin
      $display("local_alignment_score_tb: done, clean");
    end else begin
      $display("local_alignment_score_tb: done, errors");
    end
    $finish;
  end

endmodule
